// ===== rtl/led_strip_frame_formatter_macros.svh =====
// Assertion macros used by the LED strip frame formatter back end.
`ifndef LED_STRIP_FRAME_FORMATTER_MACROS_SVH
`define LED_STRIP_FRAME_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSFF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsff assertion failed");

// Next-cycle implication, disabled during reset.
`define LSFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsff assertion failed");

`endif

// ===== rtl/lsff_pkg.sv =====
// Types and constants of the LED strip frame formatter.
package lsff_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int LATCH_W         = 6;
    localparam int PIX_CNT_LIMIT_W = 11;
    localparam int LATCH_SUM_W     = 12;
    localparam int LATCH_SHIFT     = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] MAP_FOUR_MIN  = 8'd27;
    localparam logic [BYTE_W-1:0] MAP_THREE_A   = 8'd33;
    localparam logic [BYTE_W-1:0] MAP_THREE_B   = 8'd36;
    localparam logic [BYTE_W-1:0] MAP_RESET     = 8'd36;
    localparam logic [BYTE_W-1:0] FILL_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] APA_END_BYTE  = 8'h1F;
    localparam logic [2:0]        APA_BRIGHT_HI = 3'b111;

    localparam logic [LATCH_SUM_W-1:0] LATCH_ROUND = 12'd31;

    localparam logic [LATCH_W-1:0] IDX_FOUR_LAST  = 6'd3;
    localparam logic [LATCH_W-1:0] IDX_THREE_LAST = 6'd2;

    typedef enum logic [1:0] {
        CHIP_WS2801  = 2'd0,
        CHIP_WS281X  = 2'd1,
        CHIP_LPD8806 = 2'd2,
        CHIP_APA102  = 2'd3
    } chip_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CHIP_KIND       = 2'd0,
        REG_CHANNEL_MAPPING = 2'd1
    } reg_addr_t;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_END   = 2'd1,
        TAIL_LATCH = 2'd2
    } tail_kind_t;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_PIX   = 3'b010,
        PH_TAIL  = 3'b100
    } phase_t;

    typedef struct packed {
        logic                        start_frame;
        logic [3:0][BYTE_W-1:0]      pix;
        logic                        four;
        tail_kind_t                  tail;
        logic [LATCH_W-1:0]          latch_count;
        logic                        last;
    } job_t;

endpackage

// ===== rtl/lsff_channels_if.sv =====
// Handshake channel interfaces of the LED strip frame formatter.
interface lsff_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [lsff_pkg::BYTE_W-1:0]  chan_a;
    logic [lsff_pkg::BYTE_W-1:0]  chan_b;
    logic [lsff_pkg::BYTE_W-1:0]  chan_c;
    logic [lsff_pkg::BYTE_W-1:0]  chan_d;
    logic                         last_pixel;

    modport source (output valid, output chan_a, output chan_b, output chan_c,
                    output chan_d, output last_pixel, input ready);
    modport sink (input valid, input chan_a, input chan_b, input chan_c,
                  input chan_d, input last_pixel, output ready);
endinterface

interface lsff_byte_if;
    logic                         valid;
    logic                         ready;
    logic [lsff_pkg::BYTE_W-1:0]  wire_byte;
    logic                         last_byte;

    modport source (output valid, output wire_byte, output last_byte, input ready);
    modport sink (input valid, input wire_byte, input last_byte, output ready);
endinterface

interface lsff_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lsff_pkg::CFG_ADDR_W-1:0]  addr;
    logic [lsff_pkg::BYTE_W-1:0]      data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/lsff_front.sv =====
// Front end: configuration registers, pixel classification and frame counting.
module lsff_front #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    lsff_pixel_if.sink       pixel,
    lsff_cfg_if.sink         cfg,
    output lsff_pkg::job_t   job,
    output logic             job_valid,
    input  logic             job_ready
);

    localparam int PC_W = $clog2(MAX_PIXELS + 1);
    localparam logic [PC_W-1:0] PC_MAX = PC_W'(MAX_PIXELS);

    lsff_pkg::chip_kind_t              kind_reg;
    logic [lsff_pkg::BYTE_W-1:0]       map_reg;
    logic [PC_W-1:0]                   pc_reg;
    logic [PC_W-1:0]                   pc_next;
    logic                              open_reg;
    logic                              open_next;

    logic [PC_W-1:0]                   pc_inc;
    logic [lsff_pkg::LATCH_SUM_W-1:0]  latch_sum;
    logic                              four_map;
    logic                              accept;
    logic [lsff_pkg::BYTE_W-1:0]       src0;
    logic [lsff_pkg::BYTE_W-1:0]       src1;
    logic [lsff_pkg::BYTE_W-1:0]       src2;
    logic [lsff_pkg::BYTE_W-1:0]       src3;

    function automatic logic [lsff_pkg::BYTE_W-1:0] pick(
        input logic [1:0]                  sel,
        input logic [lsff_pkg::BYTE_W-1:0] a,
        input logic [lsff_pkg::BYTE_W-1:0] b,
        input logic [lsff_pkg::BYTE_W-1:0] c,
        input logic [lsff_pkg::BYTE_W-1:0] d
    );
        logic [lsff_pkg::BYTE_W-1:0] r;
        case (sel)
            2'd0:    r = a;
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    assign cfg.ready   = 1'b1;
    assign pixel.ready = job_ready;
    assign job_valid   = pixel.valid;
    assign accept      = pixel.valid && job_ready;

    assign src3 = pick(map_reg[7:6], pixel.chan_a, pixel.chan_b, pixel.chan_c, pixel.chan_d);
    assign src2 = pick(map_reg[5:4], pixel.chan_a, pixel.chan_b, pixel.chan_c, pixel.chan_d);
    assign src1 = pick(map_reg[3:2], pixel.chan_a, pixel.chan_b, pixel.chan_c, pixel.chan_d);
    assign src0 = pick(map_reg[1:0], pixel.chan_a, pixel.chan_b, pixel.chan_c, pixel.chan_d);

    assign four_map = (map_reg >= lsff_pkg::MAP_FOUR_MIN) && (map_reg != lsff_pkg::MAP_THREE_A)
                      && (map_reg != lsff_pkg::MAP_THREE_B);

    assign pc_inc    = (pc_reg < PC_MAX) ? pc_reg + 1'b1 : pc_reg;
    assign latch_sum = lsff_pkg::LATCH_SUM_W'(pc_inc) + lsff_pkg::LATCH_ROUND;
    assign pc_next   = pixel.last_pixel ? '0 : pc_inc;
    assign open_next = !pixel.last_pixel;

    always_comb
    begin
        job.start_frame = (kind_reg == lsff_pkg::CHIP_APA102) && !open_reg;
        job.latch_count = latch_sum[lsff_pkg::LATCH_SHIFT +: lsff_pkg::LATCH_W];
        job.last        = pixel.last_pixel;
        job.tail        = lsff_pkg::TAIL_NONE;
        job.four        = 1'b0;
        job.pix         = '0;
        unique case (kind_reg) inside
            lsff_pkg::CHIP_WS2801, lsff_pkg::CHIP_WS281X:
            begin
                if (four_map)
                begin
                    job.four   = 1'b1;
                    job.pix[0] = src3;
                    job.pix[1] = src2;
                    job.pix[2] = src1;
                    job.pix[3] = src0;
                end
                else
                begin
                    job.pix[0] = src2;
                    job.pix[1] = src1;
                    job.pix[2] = src0;
                end
                if (kind_reg == lsff_pkg::CHIP_WS2801)
                begin
                    job.pix = ~job.pix;
                end
            end
            lsff_pkg::CHIP_LPD8806:
            begin
                job.pix[0] = ~{1'b1, src2[7:1]};
                job.pix[1] = ~{1'b1, src1[7:1]};
                job.pix[2] = ~{1'b1, src0[7:1]};
                if (pixel.last_pixel)
                begin
                    job.tail = lsff_pkg::TAIL_LATCH;
                end
            end
            lsff_pkg::CHIP_APA102:
            begin
                job.four   = 1'b1;
                job.pix[0] = ~{lsff_pkg::APA_BRIGHT_HI, src3[7:3]};
                job.pix[1] = ~src2;
                job.pix[2] = ~src1;
                job.pix[3] = ~src0;
                if (pixel.last_pixel)
                begin
                    job.tail = lsff_pkg::TAIL_END;
                end
            end
            default:
            begin
                job.pix = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= lsff_pkg::CHIP_WS2801;
            map_reg  <= lsff_pkg::MAP_RESET;
            pc_reg   <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.addr)
                    lsff_pkg::REG_CHIP_KIND:
                        kind_reg <= lsff_pkg::chip_kind_t'(cfg.data[1:0]);
                    lsff_pkg::REG_CHANNEL_MAPPING:
                        map_reg <= cfg.data;
                    default:
                        map_reg <= map_reg;
                endcase
            end
            if (accept)
            begin
                pc_reg   <= pc_next;
                open_reg <= open_next;
            end
        end
    end

endmodule

// ===== rtl/lsff_fifo.sv =====
// Two-entry job queue between the front end and the byte sequencer.
module lsff_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  lsff_pkg::job_t  push_job,
    input  logic            push_valid,
    output logic            push_ready,
    output lsff_pkg::job_t  pop_job,
    output logic            pop_valid,
    input  logic            pop_ready
);

    lsff_pkg::job_t                    entries_reg [lsff_pkg::QUEUE_DEPTH];
    logic [lsff_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [lsff_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [lsff_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [lsff_pkg::QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [lsff_pkg::QUEUE_PTR_W:0]    count_reg;
    logic [lsff_pkg::QUEUE_PTR_W:0]    count_next;
    logic                              push;
    logic                              pop;

    assign push_ready = (count_reg != (lsff_pkg::QUEUE_PTR_W + 1)'(lsff_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/lsff_back.sv =====
// Back end: byte sequencer that turns queued jobs into the wire byte stream.
`include "led_strip_frame_formatter_macros.svh"

module lsff_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lsff_pkg::job_t  job,
    input  logic            job_valid,
    output logic            job_pop,
    lsff_byte_if.source     strip
);

    lsff_pkg::phase_t               phase_reg;
    lsff_pkg::phase_t               phase_next;
    lsff_pkg::phase_t               phase_eff;
    logic [lsff_pkg::LATCH_W-1:0]   idx_reg;
    logic [lsff_pkg::LATCH_W-1:0]   idx_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [lsff_pkg::BYTE_W-1:0]    byte_reg;
    logic                           last_reg;
    logic [lsff_pkg::BYTE_W-1:0]    byte_sel;
    logic                           done;
    logic                           emit;

    assign emit = (!out_valid_reg || strip.ready) && job_valid;
    assign job_pop = emit && done;

    assign strip.valid     = out_valid_reg;
    assign strip.wire_byte = byte_reg;
    assign strip.last_byte = last_reg;

    assign phase_eff = ((phase_reg == lsff_pkg::PH_START) && !job.start_frame) ?
                       lsff_pkg::PH_PIX : phase_reg;

    always_comb
    begin
        byte_sel   = lsff_pkg::FILL_BYTE;
        done       = 1'b0;
        phase_next = phase_eff;
        idx_next   = idx_reg + 1'b1;
        unique case (phase_eff)
            lsff_pkg::PH_START:
            begin
                if (idx_reg == lsff_pkg::IDX_FOUR_LAST)
                begin
                    phase_next = lsff_pkg::PH_PIX;
                    idx_next   = '0;
                end
            end
            lsff_pkg::PH_PIX:
            begin
                byte_sel = job.pix[idx_reg[1:0]];
                if (idx_reg == (job.four ? lsff_pkg::IDX_FOUR_LAST : lsff_pkg::IDX_THREE_LAST))
                begin
                    idx_next = '0;
                    if (job.tail == lsff_pkg::TAIL_NONE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = lsff_pkg::PH_TAIL;
                    end
                end
            end
            lsff_pkg::PH_TAIL:
            begin
                if (job.tail == lsff_pkg::TAIL_END)
                begin
                    if (idx_reg == lsff_pkg::IDX_FOUR_LAST)
                    begin
                        byte_sel = lsff_pkg::APA_END_BYTE;
                        done     = 1'b1;
                    end
                end
                else if (idx_reg == job.latch_count - 1'b1)
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                byte_sel = lsff_pkg::FILL_BYTE;
            end
        endcase
        if (done)
        begin
            phase_next = lsff_pkg::PH_START;
            idx_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (strip.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_sel;
            last_reg <= done && job.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lsff_pkg::PH_START;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
        end
    end

    `LSFF_ASSERT_IMPL(a_job_held_midway, clk, rst_n, (phase_reg != lsff_pkg::PH_START) || (idx_reg != '0), job_valid)
    `LSFF_ASSERT_IMPL(a_start_only_apa, clk, rst_n, (phase_reg == lsff_pkg::PH_START) && (idx_reg != '0), job.start_frame)
    `LSFF_ASSERT_IMPL(a_tail_has_kind, clk, rst_n, phase_reg == lsff_pkg::PH_TAIL, job.tail != lsff_pkg::TAIL_NONE)
    `LSFF_ASSERT_NEXT(a_latch_in_range, clk, rst_n, emit && (phase_next == lsff_pkg::PH_TAIL) && (job.tail == lsff_pkg::TAIL_LATCH) && !done, idx_reg < job.latch_count)

endmodule

// ===== rtl/led_strip_frame_formatter.sv =====
// Top level of the LED strip frame formatter.
// Each pixel turns into three or four wire bytes (WS2801, WS281x), three
// (LPD8806) or four (APA102), delivered one byte per clock from a registered
// output while the strip accepts them. An APA102 frame opens with four
// start-frame bytes ahead of its first pixel; after the last pixel come four
// end-frame bytes (APA102) or ceil(pixels/32) latch bytes (LPD8806). The
// byte sequencer sets the byte rate; a two-entry job queue in front of it lets
// pixels be taken while earlier ones are still being sent, so the input
// stalls only once the queue is full. Configuration writes are taken in
// every cycle and apply to pixels accepted after them.
module led_strip_frame_formatter #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    lsff_pixel_if.sink   pixel,
    lsff_byte_if.source  strip,
    lsff_cfg_if.sink     cfg
);

    lsff_pkg::job_t  push_job;
    logic            push_valid;
    logic            push_ready;
    lsff_pkg::job_t  head_job;
    logic            head_valid;
    logic            head_pop;

    lsff_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg       (cfg),
        .job       (push_job),
        .job_valid (push_valid),
        .job_ready (push_ready)
    );

    lsff_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (head_job),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop)
    );

    lsff_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (head_pop),
        .strip     (strip)
    );

endmodule
